@@ rtl/yrbd_pkg.sv @@
`timescale 1ns / 1ps
// shared widths, register indexes, reset values and stage types of the row box decoder
package yrbd_pkg;

  localparam int MAX_ROW_LENGTH_DEF = 1024;

  localparam int VALUE_W     = 32;
  localparam int SCORE_W     = 31;
  localparam int CLS_W       = 3;
  localparam int PIX_W       = 12;
  localparam int FRAME_W     = 13;
  localparam int THR_W       = 17;
  localparam int PAD_W       = 12;
  localparam int SCALE_W     = 24;
  localparam int DIFF_W      = 35;
  localparam int PROD_W      = DIFF_W + SCALE_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int OUT_TDATA_W = 88;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd5;

  localparam logic [THR_W-1:0]   THRESHOLD_RST = 17'd16384;
  localparam logic [PAD_W-1:0]   PAD_RST       = 12'd0;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 24'd65536;
  localparam logic [FRAME_W-1:0] FRAME_W_RST   = 13'd1920;
  localparam logic [FRAME_W-1:0] FRAME_H_RST   = 13'd1080;
  localparam logic [FRAME_W-1:0] FRAME_MAX     = 13'd4096;

  localparam logic [CLS_W-1:0] CLS_CAR   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_MOTO  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_BUS   = 3'd5;
  localparam logic [CLS_W-1:0] CLS_TRUCK = 3'd7;

  // finished row: box fields, winner and whether the row may still produce a box
  typedef struct packed {
    logic signed [VALUE_W-1:0] cx;
    logic signed [VALUE_W-1:0] cy;
    logic signed [VALUE_W-1:0] w;
    logic signed [VALUE_W-1:0] h;
    logic [SCORE_W-1:0]        score;
    logic [CLS_W-1:0]          cls;
    logic                      qualified;
  } row_t;

  // corners in twice-network units, pad removed
  typedef struct packed {
    logic signed [DIFF_W-1:0] dl;
    logic signed [DIFF_W-1:0] dt;
    logic signed [DIFF_W-1:0] dr;
    logic signed [DIFF_W-1:0] db;
    logic [SCORE_W-1:0]       score;
    logic [CLS_W-1:0]         cls;
  } corner_t;

  // clamped corners in frame pixels
  typedef struct packed {
    logic [PIX_W-1:0]   left;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   right;
    logic [PIX_W-1:0]   bottom;
    logic [SCORE_W-1:0] score;
    logic [CLS_W-1:0]   cls;
  } box_t;

  function automatic logic vehicle_class(input logic [15:0] idx);
    return (idx == 16'(CLS_CAR)) || (idx == 16'(CLS_MOTO)) ||
           (idx == 16'(CLS_BUS)) || (idx == 16'(CLS_TRUCK));
  endfunction

endpackage

@@ rtl/yolo_row_box_decode.sv @@
`timescale 1ns / 1ps
// top level of the detection row box decoder
// Takes one row value per cycle with no gaps needed between rows. A row's box, if kept, passes
// from its last accepted value through the row register, corner forming, the four
// 35 x 24 bit inverse-scale multipliers, round and clamp, then the size check into the result
// register. Each stage holds its item until the next one frees, so the input stalls only
// when every stage is full and the result is not being taken.
module yolo_row_box_decode import yrbd_pkg::*; #(
  parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [VALUE_W-1:0]     in_tdata,   // row_value
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // box_left, box_top, box_width, box_height, class_index, class_score, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [THR_W-1:0]   thr_r;
  logic [PAD_W-1:0]   pad_left_r, pad_top_r;
  logic [SCALE_W-1:0] inv_scale_r;
  logic [FRAME_W-1:0] frame_w_r, frame_h_r;

  logic    row_valid, row_ready, corner_valid, corner_ready, box_valid, box_ready;
  row_t    row;
  corner_t corner;
  box_t    box;

  logic [PIX_W-1:0]   out_bw, out_bh;
  logic [CLS_W-1:0]   out_cls;
  logic [SCORE_W-1:0] out_score;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RST;
      pad_left_r  <= PAD_RST;
      pad_top_r   <= PAD_RST;
      inv_scale_r <= SCALE_RST;
      frame_w_r   <= FRAME_W_RST;
      frame_h_r   <= FRAME_H_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCORE_THRESHOLD: thr_r       <= cfg_data[THR_W-1:0];
        REG_PAD_LEFT:        pad_left_r  <= cfg_data[PAD_W-1:0];
        REG_PAD_TOP:         pad_top_r   <= cfg_data[PAD_W-1:0];
        REG_INVERSE_SCALE:   inv_scale_r <= cfg_data[SCALE_W-1:0];
        REG_FRAME_WIDTH:     frame_w_r   <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT:    frame_h_r   <= cfg_data[FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  yrbd_row_acc #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
  ) u_row_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata),
    .in_last   (in_tlast),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row       (row)
  );

  yrbd_corner u_corner (
    .clk             (clk),
    .rst_n           (rst_n),
    .row_valid       (row_valid),
    .row_ready       (row_ready),
    .row             (row),
    .score_threshold (thr_r),
    .pad_left        (pad_left_r),
    .pad_top         (pad_top_r),
    .corner_valid    (corner_valid),
    .corner_ready    (corner_ready),
    .corner          (corner)
  );

  yrbd_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .corner_valid  (corner_valid),
    .corner_ready  (corner_ready),
    .corner        (corner),
    .inverse_scale (inv_scale_r),
    .frame_width   (frame_w_r),
    .frame_height  (frame_h_r),
    .box_valid     (box_valid),
    .box_ready     (box_ready),
    .box           (box)
  );

  yrbd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  assign out_bw    = out_tdata[35:24];
  assign out_bh    = out_tdata[47:36];
  assign out_cls   = out_tdata[50:48];
  assign out_score = out_tdata[81:51];

  a_vehicle_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_cls == CLS_CAR || out_cls == CLS_MOTO ||
                    out_cls == CLS_BUS || out_cls == CLS_TRUCK))
    else $error("result class is not a vehicle class");

  a_box_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_bw > PIX_W'(1) && out_bh > PIX_W'(1)))
    else $error("result box too small");

  a_score_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_score != '0))
    else $error("result score is zero");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while result side is free");

endmodule

@@ rtl/yrbd_row_acc.sv @@
`timescale 1ns / 1ps
// row accumulator: box fields, running argmax of the scores, finished-row register
module yrbd_row_acc import yrbd_pkg::*; #(
  parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_last,
  output logic               row_valid,
  input  logic               row_ready,
  output row_t               row
);

  localparam int CW = $clog2(MAX_ROW_LENGTH + 1);
  localparam int IW = $clog2(MAX_ROW_LENGTH - 4);

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, w_r, w_nxt, h_r, h_nxt;
  logic [SCORE_W-1:0] best_r, best_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic               row_valid_r;
  row_t               row_r;
  logic               take, in_range, better;
  logic [CW-1:0]      pos_off;
  logic [15:0]        idx_wide;

  assign take     = in_valid && in_ready;
  assign in_ready = !row_valid_r || row_ready;
  assign in_range = cnt_r < CW'(MAX_ROW_LENGTH);
  assign pos_off  = cnt_r - CW'(4);
  assign better   = in_range && (cnt_r >= CW'(4)) &&
                    ($signed(in_value) > $signed({1'b0, best_r}));

  always_comb begin
    cnt_nxt   = in_range ? cnt_r + CW'(1) : cnt_r;
    cx_nxt    = (in_range && cnt_r == CW'(0)) ? in_value : cx_r;
    cy_nxt    = (in_range && cnt_r == CW'(1)) ? in_value : cy_r;
    w_nxt     = (in_range && cnt_r == CW'(2)) ? in_value : w_r;
    h_nxt     = (in_range && cnt_r == CW'(3)) ? in_value : h_r;
    best_nxt  = better ? in_value[SCORE_W-1:0] : best_r;
    idx_nxt   = better ? pos_off[IW-1:0] : idx_r;
    found_nxt = found_r || better;
  end

  assign idx_wide = 16'(idx_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      best_r      <= '0;
      found_r     <= 1'b0;
      row_valid_r <= 1'b0;
    end else begin
      if (take) begin
        cnt_r   <= in_last ? '0 : cnt_nxt;
        best_r  <= in_last ? '0 : best_nxt;
        found_r <= in_last ? 1'b0 : found_nxt;
      end
      if (in_ready) begin
        row_valid_r <= take && in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      w_r   <= w_nxt;
      h_r   <= h_nxt;
      idx_r <= idx_nxt;
    end
    if (take && in_last) begin
      row_r.cx        <= cx_nxt;
      row_r.cy        <= cy_nxt;
      row_r.w         <= w_nxt;
      row_r.h         <= h_nxt;
      row_r.score     <= best_nxt;
      row_r.cls       <= idx_wide[CLS_W-1:0];
      row_r.qualified <= (cnt_nxt >= CW'(6)) && found_nxt && vehicle_class(idx_wide);
    end
  end

  assign row_valid = row_valid_r;
  assign row       = row_r;

endmodule

@@ rtl/yrbd_corner.sv @@
`timescale 1ns / 1ps
// score filter and corner forming with letterbox pad removal
module yrbd_corner import yrbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             row_valid,
  output logic             row_ready,
  input  row_t             row,
  input  logic [THR_W-1:0] score_threshold,
  input  logic [PAD_W-1:0] pad_left,
  input  logic [PAD_W-1:0] pad_top,
  output logic             corner_valid,
  input  logic             corner_ready,
  output corner_t          corner
);

  logic                     corner_valid_r;
  corner_t                  corner_r;
  logic                     keep;
  logic signed [DIFF_W-1:0] cx2, cy2, w_e, h_e, padl, padt;

  assign row_ready = !corner_valid_r || corner_ready;
  assign keep      = row.qualified && (row.score >= SCORE_W'(score_threshold));

  assign cx2  = {{2{row.cx[VALUE_W-1]}}, row.cx, 1'b0};
  assign cy2  = {{2{row.cy[VALUE_W-1]}}, row.cy, 1'b0};
  assign w_e  = {{3{row.w[VALUE_W-1]}}, row.w};
  assign h_e  = {{3{row.h[VALUE_W-1]}}, row.h};
  assign padl = {6'b0, pad_left, 17'b0};
  assign padt = {6'b0, pad_top, 17'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_valid_r <= 1'b0;
    end else if (row_ready) begin
      corner_valid_r <= row_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (row_ready && row_valid) begin
      corner_r.dl    <= cx2 - w_e - padl;
      corner_r.dr    <= cx2 + w_e - padl;
      corner_r.dt    <= cy2 - h_e - padt;
      corner_r.db    <= cy2 + h_e - padt;
      corner_r.score <= row.score;
      corner_r.cls   <= row.cls;
    end
  end

  assign corner_valid = corner_valid_r;
  assign corner       = corner_r;

endmodule

@@ rtl/yrbd_scale.sv @@
`timescale 1ns / 1ps
// inverse-scale multiply, then rounding and clamping of the four corners
module yrbd_scale import yrbd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               corner_valid,
  output logic               corner_ready,
  input  corner_t            corner,
  input  logic [SCALE_W-1:0] inverse_scale,
  input  logic [FRAME_W-1:0] frame_width,
  input  logic [FRAME_W-1:0] frame_height,
  output logic               box_valid,
  input  logic               box_ready,
  output box_t               box
);

  localparam int RND_W = PROD_W - 33;

  logic                     prod_valid_r, box_valid_r;
  logic                     prod_ready, box_load;
  logic signed [DIFF_W-1:0] diff [4];
  logic signed [PROD_W-1:0] prod_r [4];
  logic [SCORE_W-1:0]       prod_score_r;
  logic [CLS_W-1:0]         prod_cls_r;
  logic signed [SCALE_W:0]  scale_s;
  logic [FRAME_W-1:0]       fm_w, fm_h, hi_w_full, hi_h_full;
  logic [PIX_W-1:0]         hi [4];
  logic                     zero [4];
  logic [PROD_W-1:0]        rsum [4];
  logic [RND_W-1:0]         rnd [4];
  logic [PIX_W-1:0]         coord [4];
  box_t                     box_r;

  assign box_load     = !box_valid_r || box_ready;
  assign prod_ready   = !prod_valid_r || box_load;
  assign corner_ready = prod_ready;

  assign scale_s = $signed({1'b0, inverse_scale});
  assign diff[0] = corner.dl;
  assign diff[1] = corner.dt;
  assign diff[2] = corner.dr;
  assign diff[3] = corner.db;

  assign fm_w      = (frame_width > FRAME_MAX) ? FRAME_MAX : frame_width;
  assign fm_h      = (frame_height > FRAME_MAX) ? FRAME_MAX : frame_height;
  assign hi_w_full = fm_w - FRAME_W'(1);
  assign hi_h_full = fm_h - FRAME_W'(1);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hi[i]   = (i % 2 == 0) ? hi_w_full[PIX_W-1:0] : hi_h_full[PIX_W-1:0];
      zero[i] = (i % 2 == 0) ? (frame_width == '0) : (frame_height == '0);
      // round half away from zero; negative results clamp to zero anyway
      rsum[i] = {1'b0, prod_r[i][PROD_W-2:0]} + (PROD_W'(1) << 32);
      rnd[i]  = rsum[i][PROD_W-1:33];
      if (zero[i] || prod_r[i][PROD_W-1]) begin
        coord[i] = '0;
      end else if (rnd[i] > RND_W'(hi[i])) begin
        coord[i] = hi[i];
      end else begin
        coord[i] = rnd[i][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      box_valid_r  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_r <= corner_valid;
      end
      if (box_load) begin
        box_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && corner_valid) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= diff[i] * scale_s;
      end
      prod_score_r <= corner.score;
      prod_cls_r   <= corner.cls;
    end
    if (box_load && prod_valid_r) begin
      box_r.left   <= coord[0];
      box_r.top    <= coord[1];
      box_r.right  <= coord[2];
      box_r.bottom <= coord[3];
      box_r.score  <= prod_score_r;
      box_r.cls    <= prod_cls_r;
    end
  end

  assign box_valid = box_valid_r;
  assign box       = box_r;

endmodule

@@ rtl/yrbd_emit.sv @@
`timescale 1ns / 1ps
// size check and result register
module yrbd_emit import yrbd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   box_valid,
  output logic                   box_ready,
  input  box_t                   box,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data
);

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [PIX_W:0]         bw, bh;
  logic                   keep;

  assign box_ready = !out_valid_r || out_ready;
  assign bw        = {1'b0, box.right} - {1'b0, box.left};
  assign bh        = {1'b0, box.bottom} - {1'b0, box.top};
  assign keep      = !bw[PIX_W] && (bw[PIX_W-1:0] > PIX_W'(1)) &&
                     !bh[PIX_W] && (bh[PIX_W-1:0] > PIX_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (box_ready) begin
      out_valid_r <= box_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (box_ready && box_valid) begin
      out_data_r <= {6'b0, box.score, box.cls, bh[PIX_W-1:0], bw[PIX_W-1:0],
                     box.top, box.left};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
